// File: design/whtok_pkg.sv
// ----------------------------------------------------------------------------
// whtok_pkg: shared types and constants of the word hash tokenizer
// Holds the job word passed from the front end to the back end, the
// configuration register indexes and the fixed hash constants.
// ----------------------------------------------------------------------------
package whtok_pkg;

    localparam int ID_W    = 16;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int HASH_W  = 32;
    localparam int MOD_W   = 17;
    localparam int CFG_W   = 17;
    localparam int TDATA_W = 40;

    localparam logic [HASH_W-1:0]  HASH_START = 32'd5381;
    localparam int                 HASH_SHIFT = 5;
    localparam logic [7:0]         SPACE_BYTE = 8'h20;
    localparam logic [7:0]         NUL_BYTE   = 8'h00;
    localparam logic [COUNT_W-1:0] COUNT_CAP  = 11'd1024;
    localparam logic [MOD_W-1:0]   MOD_MAX    = 17'h10000;

    localparam logic [MOD_W-1:0]   VOCAB_RESET = 17'd4096;
    localparam logic [COUNT_W-1:0] MAX_RESET   = 11'd1024;

    // Configuration register indexes.
    localparam logic REG_VOCAB      = 1'b0;
    localparam logic REG_MAX_TOKENS = 1'b1;

    // One pending result: the raw hash still needs its modulo.
    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [INDEX_W-1:0] index;
        logic               valid;
        logic               is_end;
        logic [COUNT_W-1:0] count;
    } job_t;

endpackage

// File: design/whtok_queue.sv
// ----------------------------------------------------------------------------
// whtok_queue: two-entry job queue
// Decouples the byte front end from the modulo back end.
// ----------------------------------------------------------------------------
module whtok_queue
    import whtok_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: design/whtok_front.sv
// ----------------------------------------------------------------------------
// whtok_front: byte front end
// Accepts text bytes, runs the djb2 hash, tracks word and byte counts,
// holds the configuration registers and queues one job per result.
// ----------------------------------------------------------------------------
module whtok_front
    import whtok_pkg::*;
#(
    parameter int TEXT_BYTES = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_full,
    output logic             q_push,
    output job_t             q_job,
    output logic [MOD_W-1:0] modulus
);

    localparam int BC_W = $clog2(TEXT_BYTES);
    localparam logic [BC_W-1:0] BYTE_LIMIT = BC_W'(TEXT_BYTES - 1);

    logic [MOD_W-1:0]   vocab_reg;
    logic [COUNT_W-1:0] max_reg;

    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic               in_word_reg, in_word_next;
    logic [COUNT_W-1:0] word_count_reg, word_count_next;
    logic [BC_W-1:0]    byte_count_reg, byte_count_next;

    logic               accept;
    logic               close_text;
    logic [COUNT_W-1:0] limit;
    logic               room;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign close_text = s_tlast || (s_tdata == NUL_BYTE);
    assign limit      = (max_reg > COUNT_CAP) ? COUNT_CAP : max_reg;
    assign room       = in_word_reg && (word_count_reg < limit);
    assign modulus    = ((vocab_reg == '0) || (vocab_reg > MOD_MAX)) ? MOD_MAX : vocab_reg;

    always_comb begin
        hash_next       = hash_reg;
        in_word_next    = in_word_reg;
        word_count_next = word_count_reg;
        byte_count_next = byte_count_reg;
        q_push          = 1'b0;
        q_job.hash      = hash_reg;
        q_job.index     = word_count_reg[INDEX_W-1:0];
        q_job.valid     = 1'b1;
        q_job.is_end    = 1'b0;
        q_job.count     = '0;
        if (accept) begin
            if (close_text) begin
                q_push       = 1'b1;
                q_job.is_end = 1'b1;
                if (room) begin
                    q_job.count = word_count_reg + 11'd1;
                end else begin
                    q_job.index = '0;
                    q_job.valid = 1'b0;
                    q_job.count = word_count_reg;
                end
                hash_next       = HASH_START;
                in_word_next    = 1'b0;
                word_count_next = '0;
                byte_count_next = '0;
            end else if (byte_count_reg < BYTE_LIMIT) begin
                byte_count_next = byte_count_reg + 1'b1;
                if (s_tdata == SPACE_BYTE) begin
                    if (room) begin
                        q_push          = 1'b1;
                        word_count_next = word_count_reg + 11'd1;
                    end
                    in_word_next = 1'b0;
                    hash_next    = HASH_START;
                end else begin
                    hash_next    = (hash_reg << HASH_SHIFT) + hash_reg + {24'd0, s_tdata};
                    in_word_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg       <= HASH_START;
            in_word_reg    <= 1'b0;
            word_count_reg <= '0;
            byte_count_reg <= '0;
        end else begin
            hash_reg       <= hash_next;
            in_word_reg    <= in_word_next;
            word_count_reg <= word_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg <= VOCAB_RESET;
            max_reg   <= MAX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VOCAB:      vocab_reg <= cfg_wdata;
                REG_MAX_TOKENS: max_reg   <= cfg_wdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

// File: design/whtok_back.sv
// ----------------------------------------------------------------------------
// whtok_back: modulo back end
// Pops jobs, reduces the hash modulo the vocabulary size one bit per cycle
// with a restoring divider, and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module whtok_back
    import whtok_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  job_t               q_job,
    input  logic [MOD_W-1:0]   modulus,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [HASH_W-1:0]  dividend_reg, dividend_next;
    logic [MOD_W-1:0]   rem_reg, rem_next;
    logic [MOD_W-1:0]   modulus_reg;
    logic [4:0]         bit_cnt_reg, bit_cnt_next;
    job_t               job_reg;

    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_tok_reg;
    logic               out_end_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [MOD_W:0]     trial;
    logic               fits;
    logic               out_free;
    logic               load_out;

    assign trial    = {rem_reg, dividend_reg[HASH_W-1]};
    assign fits     = trial >= {1'b0, modulus_reg};
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_WAIT) && out_free;

    always_comb begin
        state_next    = state_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        bit_cnt_next  = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    dividend_next = q_job.hash;
                    rem_next      = '0;
                    bit_cnt_next  = 5'd31;
                    // A bare end marker carries id zero and skips the divider.
                    state_next    = q_job.valid ? ST_DIV : ST_WAIT;
                end
            end
            ST_DIV: begin
                rem_next      = fits ? MOD_W'(trial - {1'b0, modulus_reg}) : trial[MOD_W-1:0];
                dividend_next = {dividend_reg[HASH_W-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg - 5'd1;
                if (bit_cnt_reg == 5'd0) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        if (q_pop) begin
            job_reg     <= q_job;
            modulus_reg <= modulus;
        end
        if (load_out) begin
            out_id_reg    <= job_reg.valid ? rem_reg[ID_W-1:0] : '0;
            out_index_reg <= job_reg.index;
            out_tok_reg   <= job_reg.valid;
            out_end_reg   <= job_reg.is_end;
            out_count_reg <= job_reg.count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_count_reg, out_index_reg, out_id_reg};
    assign m_tuser  = out_tok_reg;
    assign m_tlast  = out_end_reg;

    // The remainder stays below the modulus throughout the division.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < modulus_reg))
        else $error("divider remainder out of range");

    // A bare end marker never carries a token id or index.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[25:0] == 26'd0)))
        else $error("marker word carries token data");

    // Only the closing word reports a count.
    a_count_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[36:26] == 11'd0))
        else $error("count set on a word that does not close the text");

    // A job is popped only when the output path has taken the previous one.
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DIV || state_reg == ST_WAIT))
        else $error("popped job not taken into the divider");

endmodule

// File: design/word_hash_tokenizer_unit.sv
// Path: a byte that ends a word writes a job into the queue; the back end pops it
// into the divider and loads the output register; bare end markers skip the divider.
// Throughput: one byte per cycle while the two-entry job queue has room; the
// bit-serial modulo divider takes no new word until the last reaches the output register.
// Reset: synchronous active-low aresetn clears the text state and the queue
// and loads a vocabulary size of 4096 and a word limit of 1024.
// ----------------------------------------------------------------------------
// word_hash_tokenizer_unit: djb2 word hash tokenizer
// Splits a byte stream into space-separated words and emits each word's
// hash modulo the vocabulary size with its index and the final word count.
// ----------------------------------------------------------------------------
module word_hash_tokenizer_unit
    import whtok_pkg::*;
#(
    parameter int TEXT_BYTES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] text_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [15:0] token_id, [25:16] token_index,
                                          // [36:26] token_count, [39:37] zero
    output logic               m_tuser,   // [0] token_valid
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    job_t             push_job;
    job_t             pop_job;
    logic [MOD_W-1:0] modulus;

    whtok_front #(
        .TEXT_BYTES(TEXT_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job),
        .modulus  (modulus)
    );

    whtok_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop_valid(q_valid),
        .pop      (q_pop),
        .pop_job  (pop_job)
    );

    whtok_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_job   (pop_job),
        .modulus (modulus),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
